// ===== src/tlbr_pkg.sv =====
// Types, field widths, result codes and the sequencer program of the TLB refill allocator.
package tlbr_pkg;

  localparam int PAGE_W      = 20;
  localparam int PID_W       = 8;
  localparam int FRAME_W     = 6;
  localparam int LO_W        = 12;
  localparam int INDEX_W     = 5;
  localparam int OUTCOME_W   = 2;
  localparam int VADDR_W     = 32;
  localparam int PAGE_LSB    = 13;
  localparam int REFILL_LAST = 30;

  localparam logic [LO_W-FRAME_W-1:0] LO_ATTR = 6'h16;

  localparam logic [OUTCOME_W-1:0] OUTCOME_HIT      = 2'd0;
  localparam logic [OUTCOME_W-1:0] OUTCOME_ALLOC    = 2'd1;
  localparam logic [OUTCOME_W-1:0] OUTCOME_NO_ENTRY = 2'd2;
  localparam logic [OUTCOME_W-1:0] OUTCOME_NO_FRAME = 2'd3;

  // One row of the page table holds an even/odd entry pair: the even page, the
  // owner and the even frame. The odd entry is always page+1 and frame+1.
  typedef struct packed {
    logic [PAGE_W-1:0]  page;
    logic [PID_W-1:0]   owner;
    logic [FRAME_W-1:0] frame;
  } row_t;

  typedef logic [2:0] step_t;

  // Emit sits in the last slot so that its fall-through wraps back to accept.
  localparam step_t STEP_ACCEPT  = 3'd0;
  localparam step_t STEP_READ    = 3'd1;
  localparam step_t STEP_COMPARE = 3'd2;
  localparam step_t STEP_HIT     = 3'd3;
  localparam step_t STEP_ALLOC   = 3'd4;
  localparam step_t STEP_EMIT    = 3'd7;

  typedef enum logic [2:0] {
    OP_ACCEPT,
    OP_READ,
    OP_COMPARE,
    OP_HIT,
    OP_ALLOC,
    OP_EMIT
  } step_op_t;

  typedef enum logic [2:0] {
    JC_NEXT,
    JC_ALWAYS,
    JC_NO_WORD,
    JC_SCAN_DONE,
    JC_NO_MATCH,
    JC_OUT_BUSY
  } jump_cond_t;

  typedef struct packed {
    step_op_t   op;
    jump_cond_t cond;
    step_t      target;
  } ctrl_word_t;

  // Control store: jump to target when the condition holds, else fall through.
  function automatic ctrl_word_t ucode_word(input step_t step);
    ctrl_word_t w;
    case (step)
      STEP_ACCEPT:  w = '{op: OP_ACCEPT,  cond: JC_NO_WORD,   target: STEP_ACCEPT};
      STEP_READ:    w = '{op: OP_READ,    cond: JC_SCAN_DONE, target: STEP_ALLOC};
      STEP_COMPARE: w = '{op: OP_COMPARE, cond: JC_NO_MATCH,  target: STEP_READ};
      STEP_HIT:     w = '{op: OP_HIT,     cond: JC_ALWAYS,    target: STEP_EMIT};
      STEP_ALLOC:   w = '{op: OP_ALLOC,   cond: JC_ALWAYS,    target: STEP_EMIT};
      STEP_EMIT:    w = '{op: OP_EMIT,    cond: JC_OUT_BUSY,  target: STEP_EMIT};
      default:      w = '{op: OP_ACCEPT,  cond: JC_ALWAYS,    target: STEP_ACCEPT};
    endcase
    return w;
  endfunction

endpackage

// ===== src/tlbr_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module tlbr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                       wr_data,
  input  logic                                   rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                       rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== src/tlb_refill_page_allocator.sv =====
// TLB refill allocator: page-table search and pair allocation run by a microcoded sequencer.
//
// Takes one TLB miss word at a time and returns one result word for it. The page table
// fills from entry 0 upward in even/odd pairs and is never invalidated, so a fill count
// stands in for the valid bits and no clearing pass is run after reset. Each stored pair
// costs one read step and one compare step of the sequencer. A new word is accepted only
// once the previous result has been placed in the output register.
module tlb_refill_page_allocator
  import tlbr_pkg::*;
#(
  parameter int TABLE_ENTRIES = 64,
  parameter int FRAME_COUNT   = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // bad_vaddr[31:0], process_id[39:32], probe_missed[40], zero fill[47:41]
  input  logic [47:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // entry_lo_even[11:0], entry_lo_odd[23:12], refill_index[28:24], index_written[29],
  // zero fill[31:30]
  output logic [31:0] m_tdata,
  // outcome[1:0]
  output logic [1:0]  m_tuser
);

  localparam int ROWS = TABLE_ENTRIES / 2;
  localparam int AW   = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int RW   = $clog2(ROWS + 1);
  localparam int FW   = $clog2(FRAME_COUNT + 1);

  // sequencer
  step_t      step;
  step_t      step_next;
  ctrl_word_t cw;
  logic       jump;

  // latched miss
  logic [PAGE_W-1:0] page;
  logic [PID_W-1:0]  pid;
  logic              probe;

  // allocation state
  logic [RW-1:0]      rows;
  logic [FW-1:0]      fnext;
  logic [INDEX_W-1:0] refill_counter;
  logic [INDEX_W-1:0] refill_counter_next;

  // scan and result
  logic [RW-1:0]        scan_row;
  logic                 scan_done;
  logic                 match;
  logic                 out_free;
  logic [FRAME_W-1:0]   res_frame;
  logic [OUTCOME_W-1:0] res_outcome;
  logic                 res_ok;
  logic                 entry_full;
  logic                 frame_full;

  // table RAM
  logic          ram_wr_en;
  logic          ram_rd_en;
  row_t          ram_wr_row;
  logic [$bits(row_t)-1:0] ram_rd_data;
  row_t          ram_rd_row;

  assign cw = ucode_word(step);

  assign scan_done  = (scan_row == rows);
  assign ram_rd_row = row_t'(ram_rd_data);
  assign match      = (ram_rd_row.page == page) && (ram_rd_row.owner == pid);
  assign out_free   = !m_tvalid || m_tready;
  assign entry_full = (rows == RW'(ROWS));
  assign frame_full = (fnext >= FW'(FRAME_COUNT - 1));
  assign res_ok     = !res_outcome[1];

  assign s_tready = (cw.op == OP_ACCEPT);

  always_comb begin
    case (cw.cond)
      JC_NEXT:      jump = 1'b0;
      JC_ALWAYS:    jump = 1'b1;
      JC_NO_WORD:   jump = !s_tvalid;
      JC_SCAN_DONE: jump = scan_done;
      JC_NO_MATCH:  jump = !match;
      JC_OUT_BUSY:  jump = !out_free;
      default:      jump = 1'b1;
    endcase
    step_next = jump ? cw.target : step_t'(step + 1'b1);
  end

  always_comb begin
    if (probe && res_ok) begin
      refill_counter_next = (refill_counter == INDEX_W'(REFILL_LAST)) ? '0
                                                                       : refill_counter + 1'b1;
    end else begin
      refill_counter_next = refill_counter;
    end
  end

  assign ram_rd_en  = (cw.op == OP_READ) && !scan_done;
  assign ram_wr_en  = (cw.op == OP_ALLOC) && !entry_full && !frame_full;
  assign ram_wr_row = '{page: page, owner: pid, frame: FRAME_W'(fnext)};

  tlbr_ram #(
    .WIDTH($bits(row_t)),
    .DEPTH(ROWS)
  ) u_table (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (rows[AW-1:0]),
    .wr_data (ram_wr_row),
    .rd_en   (ram_rd_en),
    .rd_addr (scan_row[AW-1:0]),
    .rd_data (ram_rd_data)
  );

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      step           <= STEP_ACCEPT;
      rows           <= '0;
      fnext          <= FW'(1);
      refill_counter <= '0;
      scan_row       <= '0;
      m_tvalid       <= 1'b0;
    end else begin
      step <= step_next;
      case (cw.op)
        OP_ACCEPT: begin
          scan_row <= '0;
        end
        OP_READ: begin
          if (!scan_done) begin
            scan_row <= RW'(scan_row + 1'b1);
          end
        end
        OP_ALLOC: begin
          if (ram_wr_en) begin
            rows  <= RW'(rows + 1'b1);
            fnext <= FW'(fnext + FW'(2));
          end
        end
        OP_EMIT: begin
          if (out_free) begin
            refill_counter <= refill_counter_next;
          end
        end
        default: begin
        end
      endcase
      if (cw.op == OP_EMIT && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    case (cw.op)
      OP_ACCEPT: begin
        if (s_tvalid) begin
          page  <= {s_tdata[VADDR_W-1:PAGE_LSB], 1'b0};
          pid   <= s_tdata[VADDR_W +: PID_W];
          probe <= s_tdata[VADDR_W + PID_W];
        end
      end
      OP_HIT: begin
        res_frame   <= ram_rd_row.frame;
        res_outcome <= OUTCOME_HIT;
      end
      OP_ALLOC: begin
        res_frame <= FRAME_W'(fnext);
        if (entry_full) begin
          res_outcome <= OUTCOME_NO_ENTRY;
        end else if (frame_full) begin
          res_outcome <= OUTCOME_NO_FRAME;
        end else begin
          res_outcome <= OUTCOME_ALLOC;
        end
      end
      OP_EMIT: begin
        if (out_free) begin
          m_tdata[LO_W-1:0]           <= res_ok ? {res_frame, LO_ATTR} : '0;
          m_tdata[2*LO_W-1:LO_W]      <= res_ok ? {FRAME_W'(res_frame + 1'b1), LO_ATTR} : '0;
          m_tdata[2*LO_W +: INDEX_W]  <= refill_counter_next;
          m_tdata[2*LO_W + INDEX_W]   <= probe && res_ok;
          m_tdata[31:2*LO_W+INDEX_W+1] <= '0;
          m_tuser                     <= res_outcome;
        end
      end
      default: begin
      end
    endcase
  end

  // a fresh miss always starts the table scan
  a_accept_starts_scan: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> (step == STEP_READ && scan_row == '0))
    else $error("accepted word did not start a scan");

  // frame 0 stays reserved: pairs are handed out from odd frames
  a_frame_odd: assert property (@(posedge clk) disable iff (rst)
    fnext[0] == 1'b1)
    else $error("frame allocation lost pair alignment");

  a_rows_bound: assert property (@(posedge clk) disable iff (rst)
    (rows <= RW'(ROWS)) && (scan_row <= rows))
    else $error("fill count or scan row out of range");

  a_refill_range: assert property (@(posedge clk) disable iff (rst)
    refill_counter <= INDEX_W'(REFILL_LAST))
    else $error("refill counter left its range");

  a_result_from_emit: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> ($past(cw.op) == OP_EMIT))
    else $error("result raised outside the emit step");

endmodule

// ===== test/tb.sv =====
// Self-checking testbench for the TLB refill page allocator: a page-table mirror predicts every refill word.
`timescale 1ns / 1ps

module tb
  import tlbr_pkg::*;
();

  localparam int TABLE_ENTRIES = 64;
  localparam int FRAME_COUNT   = 64;
  localparam int RANDOM_WORDS  = 1500;
  localparam int MAX_GAP       = 8;
  localparam int DRAIN_CYCLES  = 80;
  localparam int CYCLE_LIMIT   = 600000;

  typedef struct packed {
    logic [LO_W-1:0]      lo_even;
    logic [LO_W-1:0]      lo_odd;
    logic [INDEX_W-1:0]   index;
    logic                 written;
    logic [OUTCOME_W-1:0] outcome;
  } refill_t;

  // Mirror of the page table, frame map and refill counter.
  class page_table_mirror;
    logic [TABLE_ENTRIES-1:0][PAGE_W-1:0] entry_page  = '0;
    logic [TABLE_ENTRIES-1:0][15:0]       entry_frame = '0;
    logic [TABLE_ENTRIES-1:0][PID_W-1:0]  entry_owner = '0;
    logic [TABLE_ENTRIES-1:0]             entry_valid = '0;
    logic [FRAME_COUNT-1:0]               frame_used  = '0;
    logic [INDEX_W-1:0]                   refill_ctr  = '0;
    refill_t pending_refills[$];
    int mismatches = 0;
    int hits = 0;
    int allocs = 0;
    int no_entry = 0;
    int no_frame = 0;
    int index_moves = 0;

    function logic [LO_W-1:0] lo_word(input int frame);
      int w;
      w = ((frame << FRAME_W) | LO_ATTR) & 'hfff;
      return w[LO_W-1:0];
    endfunction

    function void record_miss(input logic [VADDR_W-1:0] vaddr, input logic [PID_W-1:0] pid,
                              input logic probe_miss);
      logic [PAGE_W-1:0] page;
      int row;
      int free_row;
      int free_frame;
      refill_t r;
      page = {vaddr[31:PAGE_LSB], 1'b0};
      r = '0;
      row = -1;
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        if (row < 0 && entry_valid[i] && entry_page[i] == page && entry_owner[i] == pid)
          row = i;
      end
      if (row >= 0) begin
        r.outcome = OUTCOME_HIT;
        hits++;
      end else begin
        free_row = TABLE_ENTRIES;
        for (int i = TABLE_ENTRIES - 1; i >= 0; i--)
          if (!entry_valid[i]) free_row = i;
        if (free_row + 1 >= TABLE_ENTRIES) begin
          r.outcome = OUTCOME_NO_ENTRY;
        end else begin
          // frame 0 is reserved, so the search starts at 1
          free_frame = FRAME_COUNT;
          for (int j = FRAME_COUNT - 1; j >= 1; j--)
            if (!frame_used[j]) free_frame = j;
          if (free_frame + 1 >= FRAME_COUNT) begin
            r.outcome = OUTCOME_NO_FRAME;
          end else begin
            row = free_row;
            entry_page[row]      = page;
            entry_frame[row]     = 16'(free_frame);
            entry_owner[row]     = pid;
            entry_valid[row]     = 1'b1;
            entry_page[row+1]    = page + 1'b1;
            entry_frame[row+1]   = 16'(free_frame + 1);
            entry_owner[row+1]   = pid;
            entry_valid[row+1]   = 1'b1;
            frame_used[free_frame]   = 1'b1;
            frame_used[free_frame+1] = 1'b1;
            r.outcome = OUTCOME_ALLOC;
            allocs++;
          end
        end
      end
      if (r.outcome == OUTCOME_NO_ENTRY || r.outcome == OUTCOME_NO_FRAME) begin
        if (r.outcome == OUTCOME_NO_ENTRY) no_entry++;
        else no_frame++;
        r.index = refill_ctr;
      end else begin
        if (probe_miss) begin
          refill_ctr = (refill_ctr == REFILL_LAST) ? '0 : refill_ctr + 1'b1;
          index_moves++;
        end
        r.lo_even = lo_word(entry_frame[row]);
        r.lo_odd  = (row + 1 < TABLE_ENTRIES) ? lo_word(entry_frame[row+1]) : '0;
        r.index   = refill_ctr;
        r.written = probe_miss;
      end
      pending_refills.push_back(r);
    endfunction

    function void check_refill(input logic [31:0] data, input logic [1:0] user);
      refill_t want;
      if (pending_refills.size() == 0) begin
        $error("refill word with nothing pending: tdata %h tuser %0d", data, user);
        mismatches++;
        return;
      end
      want = pending_refills.pop_front();
      if (data[11:0] !== want.lo_even) begin
        $error("entry_lo_even: expected %h, got %h", want.lo_even, data[11:0]);
        mismatches++;
      end
      if (data[23:12] !== want.lo_odd) begin
        $error("entry_lo_odd: expected %h, got %h", want.lo_odd, data[23:12]);
        mismatches++;
      end
      if (data[28:24] !== want.index) begin
        $error("refill_index: expected %0d, got %0d", want.index, data[28:24]);
        mismatches++;
      end
      if (data[29] !== want.written) begin
        $error("index_written: expected %0d, got %0d", want.written, data[29]);
        mismatches++;
      end
      if (user !== want.outcome) begin
        $error("outcome: expected %0d, got %0d", want.outcome, user);
        mismatches++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [47:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;
  logic [1:0]  m_tuser;

  page_table_mirror board;
  logic [26:0] seen_keys[$];   // {vaddr[31:13], pid} of every word sent
  int send_idle_pct  = 0;
  int stall_pct      = 0;
  int stall_run      = 0;
  int cycle_count    = 0;
  int words_sent     = 0;

  tlb_refill_page_allocator #(
    .TABLE_ENTRIES(TABLE_ENTRIES),
    .FRAME_COUNT  (FRAME_COUNT)
  ) dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Result side: check each accepted word, then pick next cycle's ready.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) board.check_refill(m_tdata, m_tuser);
    if (stall_run < MAX_GAP && $urandom_range(99, 0) < stall_pct) begin
      m_tready  <= 1'b0;
      stall_run <= stall_run + 1;
    end else begin
      m_tready  <= 1'b1;
      stall_run <= 0;
    end
  end

  // Call at a rising edge; returns at the edge where the word was taken.
  task automatic send_miss(input logic [31:0] vaddr, input logic [7:0] pid,
                           input logic probe_miss);
    int gap = 0;
    while (gap < MAX_GAP && $urandom_range(99, 0) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
      gap++;
    end
    s_tdata  <= {7'b0, probe_miss, pid, vaddr};
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    board.record_miss(vaddr, pid, probe_miss);
    seen_keys.push_back({vaddr[31:13], pid});
    words_sent++;
  endtask

  // Mostly revisit known pages with fresh offset bits; the rest are new addresses.
  task automatic send_random_miss();
    logic [31:0] vaddr;
    logic [7:0]  pid;
    logic [26:0] key;
    vaddr = $urandom;
    pid   = 8'($urandom_range(255, 0));
    if (seen_keys.size() != 0 && $urandom_range(99, 0) < 60) begin
      key = seen_keys[$urandom_range(seen_keys.size() - 1, 0)];
      vaddr[31:13] = key[26:8];
      pid = key[7:0];
    end
    send_miss(vaddr, pid, 1'($urandom_range(1, 0)));
  endtask

  initial begin
    board = new;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed: field extremes, offset bit 12, owner mismatch, odd-page lookups.
    send_miss(32'h0000_0000, 8'd0,   1'b1);
    send_miss(32'h0000_1fff, 8'd0,   1'b0);
    send_miss(32'h0000_0000, 8'd255, 1'b1);
    send_miss(32'hffff_ffff, 8'd255, 1'b0);
    send_miss(32'hffff_e000, 8'd255, 1'b1);
    send_miss(32'hffff_ffff, 8'd0,   1'b1);
    send_miss(32'h0000_2000, 8'd0,   1'b0);
    send_miss(32'h0000_1000, 8'd0,   1'b1);
    send_miss(32'haaaa_aaaa, 8'h55,  1'b1);
    send_miss(32'h5555_5555, 8'haa,  1'b0);
    send_miss(32'haaaa_b555, 8'h55,  1'b1);

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 66; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 66; end
        default: begin send_idle_pct = 29; stall_pct = 29; end
      endcase
      for (int n = 0; n < RANDOM_WORDS / 4; n++) send_random_miss();
    end
    s_tvalid <= 1'b0;

    while (board.pending_refills.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d miss words: %0d table hits, %0d pair allocations,",
             words_sent, board.hits, board.allocs);
    $display("%0d out of frames, %0d out of entries; refill index advanced %0d times",
             board.no_frame, board.no_entry, board.index_moves);
    if (board.mismatches == 0 && board.pending_refills.size() == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
